// File: sv/linear_probe_hash_table_assert.svh
// Assertion macros for the linear probing hash table.
// Expects i_clk and i_rst_n in the scope of the module that uses them.
`ifndef LINEAR_PROBE_HASH_TABLE_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_ASSERT_SVH

// Check a condition at every clock edge out of reset
`define LPHT_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("lpht: assertion failed");

// Check that a condition implies another one in the next cycle
`define LPHT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lpht: assertion failed");

`endif

// File: sv/lpht_pkg.sv
// Shared types and constants of the linear probing hash table.
// No dependencies; used by the channel interfaces and the top level.
package lpht_pkg;

    // Field widths
    localparam int FUNC_W = 2;
    localparam int KEY_W  = 32;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int CFG_W  = 9;
    localparam int CNT_W  = 9;
    localparam int MARK_W = 2;

    // Bucket count after reset
    localparam logic [CFG_W-1:0] BUCKET_RESET = 9'd89;

    // Home bucket remainder: quotient bits resolved per cycle
    localparam int MOD_BITS   = 4;
    localparam int MOD_CYCLES = KEY_W / MOD_BITS;
    localparam int MOD_CNT_W  = $clog2(MOD_CYCLES);

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_FIND   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NOP    = 2'd3;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

    // Bucket marks
    localparam logic [MARK_W-1:0] MARK_EMPTY   = 2'd0;
    localparam logic [MARK_W-1:0] MARK_USED    = 2'd1;
    localparam logic [MARK_W-1:0] MARK_DELETED = 2'd2;

    // One bucket as stored in the table memory
    typedef struct packed {
        logic [MARK_W-1:0] mark;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
    } t_entry;

    // Sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_NOP,
        S_MOD,
        S_READ,
        S_CHECK
    } t_state;

endpackage

// File: sv/lpht_req_if.sv
// Request channel of the hash table: operation, key and value.
// Depends on lpht_pkg for the field widths.
interface lpht_req_if;
    logic                         valid;
    logic                         ready;
    logic [lpht_pkg::FUNC_W-1:0]  func;
    logic [lpht_pkg::KEY_W-1:0]   key;
    logic [lpht_pkg::VAL_W-1:0]   value_in;

    modport source (output valid, func, key, value_in, input ready);
    modport sink   (input valid, func, key, value_in, output ready);
endinterface

// File: sv/lpht_rsp_if.sv
// Result channel of the hash table: status, value and entry count.
// Depends on lpht_pkg for the field widths.
interface lpht_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [lpht_pkg::STAT_W-1:0]  status;
    logic [lpht_pkg::VAL_W-1:0]   value_out;
    logic [lpht_pkg::CNT_W-1:0]   entry_count;

    modport source (output valid, status, value_out, entry_count, input ready);
    modport sink   (input valid, status, value_out, entry_count, output ready);
endinterface

// File: sv/linear_probe_hash_table.sv
// Linear probing hash table, top level with the bucket memory and sequencer.
// Depends on lpht_pkg, lpht_req_if, lpht_rsp_if and the assertion header.
//
// Usage:
// - i_req carries one request: func (find, insert, remove, no-op), key and
//   value_in. It is accepted when valid and ready are both high.
// - o_rsp returns one result per request: status, value_out and the number
//   of used buckets after the operation, in request order.
// - i_cfg_we / i_cfg_data write the bucket count; write it only while idle.
// Sequence: an accepted request goes straight into the home bucket
// remainder (four quotient bits a cycle), then the first bucket read,
// then one probed bucket per cycle, set by the single read port of the
// bucket memory. A no-op skips these steps and goes straight to loading
// its result. One request is in work at a time; the next is taken the
// cycle after the result is loaded into the output register.
// Reset: a clearing pass marks all MAX_BUCKETS buckets empty, one a cycle,
// during which i_req.ready stays low; configuration writes are still taken.
// Stall: the result waits in the output register; a new request is still
// taken, and its result is held back until the register is free.
`include "linear_probe_hash_table_assert.svh"

module linear_probe_hash_table #(
    parameter int MAX_BUCKETS = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    lpht_req_if.sink                      i_req,
    lpht_rsp_if.source                    o_rsp,
    input  logic                          i_cfg_we,
    input  logic [lpht_pkg::CFG_W-1:0]    i_cfg_data
);

    localparam int IDX_W = $clog2(MAX_BUCKETS);
    localparam int CFG_W = lpht_pkg::CFG_W;

    // Registers
    lpht_pkg::t_state                  r_state, n_state;
    logic [CFG_W-1:0]                  r_cfg;
    logic [IDX_W-1:0]                  r_clr, n_clr;
    logic [lpht_pkg::FUNC_W-1:0]       r_func, n_func;
    logic [lpht_pkg::KEY_W-1:0]        r_key, n_key;
    logic [lpht_pkg::VAL_W-1:0]        r_val, n_val;
    logic [lpht_pkg::KEY_W-1:0]        r_div, n_div;
    logic [CFG_W-1:0]                  r_rem, n_rem;
    logic [lpht_pkg::MOD_CNT_W-1:0]    r_mod_cnt, n_mod_cnt;
    logic [CFG_W-1:0]                  r_idx, n_idx;
    logic [CFG_W-1:0]                  r_step, n_step;
    logic [lpht_pkg::CNT_W-1:0]        r_used, n_used;
    logic                              r_out_valid, n_out_valid;
    logic [lpht_pkg::STAT_W-1:0]       r_out_status, n_out_status;
    logic [lpht_pkg::VAL_W-1:0]        r_out_value, n_out_value;
    logic [lpht_pkg::CNT_W-1:0]        r_out_count, n_out_count;

    // Bucket memory
    lpht_pkg::t_entry                  r_mem [MAX_BUCKETS];
    lpht_pkg::t_entry                  r_rd_data;

    // Combinational signals
    logic [CFG_W-1:0]                  w_n;
    logic [CFG_W-1:0]                  w_rem_next;
    logic [CFG_W-1:0]                  w_next_idx;
    logic                              w_last;
    logic                              w_out_free;
    logic                              w_out_load;
    logic                              w_we;
    logic [IDX_W-1:0]                  w_waddr;
    lpht_pkg::t_entry                  w_wdata;
    logic                              w_re;
    logic [IDX_W-1:0]                  w_raddr;
    logic                              w_is_used;
    logic                              w_is_empty;
    logic                              w_kmatch;

    // Clamp the bucket count to the range 1 .. MAX_BUCKETS
    always_comb begin
        if (r_cfg == '0) begin
            w_n = CFG_W'(1);
        end else if (int'(r_cfg) > MAX_BUCKETS) begin
            w_n = CFG_W'(MAX_BUCKETS);
        end else begin
            w_n = r_cfg;
        end
    end

    // Advance the remainder by MOD_BITS dividend bits
    always_comb begin
        logic [CFG_W:0]   rem_t;
        logic [CFG_W-1:0] rem;
        rem = r_rem;
        for (int b = 0; b < lpht_pkg::MOD_BITS; b++) begin
            rem_t = {rem, r_div[lpht_pkg::KEY_W-1-b]};
            if (rem_t >= {1'b0, w_n}) begin
                rem_t = rem_t - {1'b0, w_n};
            end
            rem = rem_t[CFG_W-1:0];
        end
        w_rem_next = rem;
    end

    // Probe position and bucket decode
    assign w_last     = (r_step + CFG_W'(1)) == w_n;
    assign w_next_idx = ((r_idx + CFG_W'(1)) == w_n) ? '0 : r_idx + CFG_W'(1);
    assign w_is_used  = r_rd_data.mark == lpht_pkg::MARK_USED;
    assign w_is_empty = r_rd_data.mark == lpht_pkg::MARK_EMPTY;
    assign w_kmatch   = r_rd_data.key == r_key;
    assign w_out_free = !r_out_valid || o_rsp.ready;

    // Next state, memory access and result
    always_comb begin
        logic hit;
        logic stop;
        n_state      = r_state;
        n_clr        = r_clr;
        n_func       = r_func;
        n_key        = r_key;
        n_val        = r_val;
        n_div        = r_div;
        n_rem        = r_rem;
        n_mod_cnt    = r_mod_cnt;
        n_idx        = r_idx;
        n_step       = r_step;
        n_used       = r_used;
        n_out_status = r_out_status;
        n_out_value  = r_out_value;
        n_out_count  = r_out_count;
        w_out_load   = 1'b0;
        w_we         = 1'b0;
        w_waddr      = IDX_W'(r_idx);
        w_wdata      = '{mark: lpht_pkg::MARK_EMPTY, key: '0, value: '0};
        w_re         = 1'b0;
        w_raddr      = IDX_W'(r_idx);
        i_req.ready  = 1'b0;
        hit          = 1'b0;
        stop         = 1'b0;

        unique case (r_state)
            lpht_pkg::S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                if (r_clr == IDX_W'(MAX_BUCKETS - 1)) begin
                    n_state = lpht_pkg::S_IDLE;
                end else begin
                    n_clr = r_clr + IDX_W'(1);
                end
            end
            lpht_pkg::S_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_func    = i_req.func;
                    n_key     = i_req.key;
                    n_val     = i_req.value_in;
                    n_div     = i_req.key;
                    n_rem     = '0;
                    n_mod_cnt = '0;
                    n_state   = (i_req.func == lpht_pkg::FUNC_NOP) ?
                                lpht_pkg::S_NOP : lpht_pkg::S_MOD;
                end
            end
            lpht_pkg::S_NOP: begin
                if (w_out_free) begin
                    w_out_load   = 1'b1;
                    n_out_status = lpht_pkg::ST_OK;
                    n_out_value  = '0;
                    n_out_count  = r_used;
                    n_state      = lpht_pkg::S_IDLE;
                end
            end
            lpht_pkg::S_MOD: begin
                n_rem     = w_rem_next;
                n_div     = r_div << lpht_pkg::MOD_BITS;
                n_mod_cnt = r_mod_cnt + lpht_pkg::MOD_CNT_W'(1);
                if (r_mod_cnt == lpht_pkg::MOD_CNT_W'(lpht_pkg::MOD_CYCLES - 1)) begin
                    n_idx   = w_rem_next;
                    n_step  = '0;
                    n_state = lpht_pkg::S_READ;
                end
            end
            lpht_pkg::S_READ: begin
                w_re    = 1'b1;
                w_raddr = IDX_W'(r_idx);
                n_state = lpht_pkg::S_CHECK;
            end
            lpht_pkg::S_CHECK: begin
                // Decide whether this bucket ends the probe
                if (r_func == lpht_pkg::FUNC_INSERT) begin
                    hit  = !w_is_used || w_kmatch;
                    stop = hit || w_last;
                end else begin
                    hit  = w_is_used && w_kmatch;
                    stop = hit || w_is_empty || w_last;
                end

                if (!stop) begin
                    // Advance to the next bucket and read it
                    w_re    = 1'b1;
                    w_raddr = IDX_W'(w_next_idx);
                    n_idx   = w_next_idx;
                    n_step  = r_step + CFG_W'(1);
                end else if (w_out_free) begin
                    // Finish: update the bucket on an insert or remove hit and load the result
                    w_out_load   = 1'b1;
                    n_state      = lpht_pkg::S_IDLE;
                    n_out_status = lpht_pkg::ST_OK;
                    n_out_value  = '0;
                    case (r_func)
                        lpht_pkg::FUNC_INSERT: begin
                            if (hit) begin
                                w_we    = 1'b1;
                                w_wdata = '{mark: lpht_pkg::MARK_USED, key: r_key,
                                            value: r_val};
                                if (!w_is_used) begin
                                    n_used = r_used + lpht_pkg::CNT_W'(1);
                                end
                            end else begin
                                n_out_status = lpht_pkg::ST_FULL;
                            end
                        end
                        lpht_pkg::FUNC_REMOVE: begin
                            if (hit) begin
                                w_we        = 1'b1;
                                w_wdata     = '{mark: lpht_pkg::MARK_DELETED, key: '0,
                                                value: '0};
                                n_out_value = r_rd_data.value;
                                if (r_used != '0) begin
                                    n_used = r_used - lpht_pkg::CNT_W'(1);
                                end
                            end else begin
                                n_out_status = lpht_pkg::ST_MISS;
                            end
                        end
                        default: begin
                            if (hit) begin
                                n_out_value = r_rd_data.value;
                            end else begin
                                n_out_status = lpht_pkg::ST_MISS;
                            end
                        end
                    endcase
                    n_out_count = n_used;
                end
            end
            default: begin
                n_state = lpht_pkg::S_IDLE;
            end
        endcase

        // Hold the result until taken, then drop it
        if (w_out_load) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lpht_pkg::S_CLEAR;
            r_clr       <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
        end
    end

    // Bucket count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= lpht_pkg::BUCKET_RESET;
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_data;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_func       <= n_func;
        r_key        <= n_key;
        r_val        <= n_val;
        r_div        <= n_div;
        r_rem        <= n_rem;
        r_mod_cnt    <= n_mod_cnt;
        r_idx        <= n_idx;
        r_step       <= n_step;
        r_out_status <= n_out_status;
        r_out_value  <= n_out_value;
        r_out_count  <= n_out_count;
    end

    // Bucket memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd_data <= r_mem[w_raddr];
        end
    end

    // Result channel
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.value_out   = r_out_value;
    assign o_rsp.entry_count = r_out_count;

    // Assertions
    `LPHT_ASSERT_ALWAYS(a_no_rw_overlap, !(w_we && w_re))
    `LPHT_ASSERT_ALWAYS(a_load_when_free, !w_out_load || !r_out_valid || o_rsp.ready)
    `LPHT_ASSERT_ALWAYS(a_step_in_range, (r_state != lpht_pkg::S_CHECK) || (r_step < w_n))
    `LPHT_ASSERT_ALWAYS(a_count_bound, int'(r_used) <= MAX_BUCKETS)
    `LPHT_ASSERT_NEXT(a_count_only_on_finish, r_state != lpht_pkg::S_CHECK, $stable(r_used))

endmodule
